// ----- design/dnsrx_pkg.sv -----
// Shared types and constants for the DNS response record extractor.
package dnsrx_pkg;

    localparam int IDX_W          = 6;
    localparam int NAME_CHARS_DEF = 63;

    typedef struct packed {
        logic [31:0]      addr;
        logic             ip_found;
        logic [15:0]      port;
        logic [IDX_W-1:0] len;
        logic             bank;
    } t_summary;

    typedef struct packed {
        logic             en;
        logic [IDX_W:0]   addr;
        logic [7:0]       data;
    } t_name_wr;

endpackage

// ----- design/dns_response_record_extractor_unit.sv -----
// DNS response record extractor: byte-stream parser and result run emitter.
//
// Input channel (i_valid/o_ready): one packet byte per item, i_pkt_last on
// the final byte. The parser takes one byte every cycle while o_ready is
// high, so the sustained input rate is one item per cycle.
// Output channel (o_valid/i_ready): per packet a run of results, one per
// kept name character (one result if no name), o_run_end on the last. The
// summary is queued when the last byte is accepted; each result passes the
// registered read of the name memory, then the output register, and the
// run streams at one result per cycle while i_ready is high.
// The name memory has two banks, so the parser works on a new packet while
// the previous run drains. o_ready drops only when both banks hold runs not
// yet read out; a stalled receiver holds its result in the output register.
// Reset (synchronous, active low) empties the queue and the output stage and
// puts the parser back to the start of a packet. Name memory needs no clear.
module dns_response_record_extractor_unit #(
    parameter int NAME_CHARS = dnsrx_pkg::NAME_CHARS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_pkt_byte,
    input  logic                        i_pkt_last,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [31:0]                 o_ipv4_addr,
    output logic                        o_ip_found,
    output logic [15:0]                 o_srv_port,
    output logic [dnsrx_pkg::IDX_W-1:0] o_name_length,
    output logic [7:0]                  o_name_char,
    output logic                        o_run_end
);
    import dnsrx_pkg::*;

    logic       push;
    t_summary   sum;
    t_name_wr   wr;
    logic [1:0] busy;

    dnsrx_front #(.NAME_CHARS(NAME_CHARS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_pkt_byte(i_pkt_byte), .i_pkt_last(i_pkt_last), .i_busy(busy),
        .o_push(push), .o_sum(sum), .o_wr(wr)
    );

    dnsrx_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_sum(sum), .i_wr(wr),
        .o_busy(busy), .o_valid(o_valid), .i_ready(i_ready),
        .o_ipv4_addr(o_ipv4_addr), .o_ip_found(o_ip_found), .o_srv_port(o_srv_port),
        .o_name_length(o_name_length), .o_name_char(o_name_char), .o_run_end(o_run_end)
    );

endmodule

// ----- design/dnsrx_front.sv -----
// Packet parser: walks header, questions and records one byte per cycle while o_ready is high.
module dnsrx_front #(
    parameter int NAME_CHARS = dnsrx_pkg::NAME_CHARS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_pkt_byte,
    input  logic                i_pkt_last,
    input  logic [1:0]          i_busy,
    output logic                o_push,
    output dnsrx_pkg::t_summary o_sum,
    output dnsrx_pkg::t_name_wr o_wr
);
    import dnsrx_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER, PH_NAME, PH_NAME_PTR, PH_QTAIL, PH_FIXED, PH_RDATA, PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        TM_0, TM_1, TM_2, TM_COPY, TM_MISS
    } t_match;

    localparam logic [IDX_W-1:0] NameMax = IDX_W'(NAME_CHARS);

    t_phase r_phase, n_phase;
    t_match r_match, n_match;
    logic [3:0]       r_hdr_idx, n_hdr_idx, r_fix_idx, n_fix_idx;
    logic [15:0]      r_q_left, n_q_left, r_kind, n_kind, r_len, n_len, r_off, n_off;
    logic [17:0]      r_rec, n_rec;
    logic [7:0]       r_label, n_label, r_str_left, n_str_left;
    logic [31:0]      r_addr_t, n_addr_t, r_addr_k, n_addr_k;
    logic             r_addr_v, n_addr_v, r_stop, n_stop, r_wbank, n_wbank;
    logic [15:0]      r_port_t, n_port_t, r_port_k, n_port_k;
    logic [IDX_W-1:0] r_len_k, n_len_k, r_len_t, n_len_t, r_emit, n_emit;

    logic       acc;
    logic [7:0] b;
    logic [15:0] room;
    logic [7:0]  dec;

    assign o_ready = !i_busy[r_wbank];
    assign acc     = i_valid && o_ready;
    assign b       = i_pkt_byte;
    assign room    = r_len - 16'd1 - r_off;
    assign dec     = r_str_left - 8'd1;

    always_comb begin
        n_phase = r_phase; n_match = r_match; n_hdr_idx = r_hdr_idx; n_fix_idx = r_fix_idx;
        n_q_left = r_q_left; n_kind = r_kind; n_len = r_len; n_off = r_off; n_rec = r_rec;
        n_label = r_label; n_str_left = r_str_left; n_addr_t = r_addr_t; n_addr_k = r_addr_k;
        n_addr_v = r_addr_v; n_stop = r_stop; n_wbank = r_wbank; n_port_t = r_port_t;
        n_port_k = r_port_k; n_len_k = r_len_k; n_len_t = r_len_t; n_emit = r_emit;
        o_wr   = '0;
        o_push = 1'b0;
        o_sum  = '0;
        if (acc) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_hdr_idx == 4'd4) n_q_left = {b, 8'h00};
                    else if (r_hdr_idx == 4'd5) n_q_left = {r_q_left[15:8], b};
                    else if (r_hdr_idx inside {4'd6, 4'd8, 4'd10})
                        n_rec = r_rec + {2'b00, b, 8'h00};
                    else if (r_hdr_idx inside {4'd7, 4'd9, 4'd11})
                        n_rec = r_rec + {10'h000, b};
                    n_hdr_idx = r_hdr_idx + 4'd1;
                    if (r_hdr_idx >= 4'd11) begin
                        n_label = '0;
                        n_phase = (n_q_left != 0 || n_rec != 0) ? PH_NAME : PH_DONE;
                    end
                end
                PH_NAME: begin
                    if (r_label != 0) n_label = r_label - 8'd1;
                    else if (b == 8'd0) begin
                        n_fix_idx = '0;
                        n_phase   = (r_q_left != 0) ? PH_QTAIL : PH_FIXED;
                    end else if (b[7:6] == 2'b11) n_phase = PH_NAME_PTR;
                    else n_label = b;
                end
                PH_NAME_PTR: begin
                    n_fix_idx = '0;
                    n_phase   = (r_q_left != 0) ? PH_QTAIL : PH_FIXED;
                end
                PH_QTAIL: begin
                    n_fix_idx = r_fix_idx + 4'd1;
                    if (n_fix_idx >= 4'd4) begin
                        n_fix_idx = '0;
                        n_q_left  = r_q_left - 16'd1;
                        n_label   = '0;
                        n_phase   = (n_q_left != 0 || r_rec != 0) ? PH_NAME : PH_DONE;
                    end
                end
                PH_FIXED: begin
                    if (r_fix_idx == 4'd0) n_kind = {b, 8'h00};
                    else if (r_fix_idx == 4'd1) n_kind = {r_kind[15:8], b};
                    else if (r_fix_idx == 4'd8) n_len = {b, 8'h00};
                    else if (r_fix_idx == 4'd9) n_len = {r_len[15:8], b};
                    n_fix_idx = r_fix_idx + 4'd1;
                    if (r_fix_idx >= 4'd9) begin
                        n_fix_idx = '0; n_off = '0; n_addr_t = '0; n_port_t = '0;
                        n_str_left = '0; n_match = TM_0; n_stop = 1'b0;
                        n_len_t = '0; n_emit = '0;
                        if (n_len == 16'd0) begin
                            n_rec   = r_rec - 18'd1;
                            n_label = '0;
                            n_phase = (r_q_left != 0 || n_rec != 0) ? PH_NAME : PH_DONE;
                        end else begin
                            n_phase = PH_RDATA;
                        end
                    end
                end
                PH_RDATA: begin
                    if (r_kind == 16'd1 && r_off < 16'd4)
                        n_addr_t = {r_addr_t[23:0], b};
                    else if (r_kind == 16'd33 && r_off == 16'd4)
                        n_port_t = {b, 8'h00};
                    else if (r_kind == 16'd33 && r_off == 16'd5)
                        n_port_t = {r_port_t[15:8], b};
                    else if (r_kind == 16'd16 && !r_stop && r_len_k == 0) begin
                        if (r_str_left == 0) begin
                            if ({8'h00, b} > room) n_stop = 1'b1;
                            else begin
                                n_str_left = b;
                                n_match    = (b > 8'd3) ? TM_0 : TM_MISS;
                            end
                        end else begin
                            n_str_left = dec;
                            case (r_match)
                                TM_0: n_match = (b == 8'h66) ? TM_1 : TM_MISS;
                                TM_1: n_match = (b == 8'h6e) ? TM_2 : TM_MISS;
                                TM_2: begin
                                    if (b == 8'h3d) begin
                                        n_match = TM_COPY;
                                        n_len_t = (dec > 8'(NAME_CHARS)) ? NameMax
                                                                         : dec[IDX_W-1:0];
                                        n_emit  = '0;
                                    end else begin
                                        n_match = TM_MISS;
                                    end
                                end
                                TM_COPY: begin
                                    if (r_emit < NameMax) begin
                                        o_wr.en   = 1'b1;
                                        o_wr.addr = {r_wbank, r_emit};
                                        o_wr.data = b;
                                        n_emit    = r_emit + 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    if ({1'b0, r_off} + 17'd1 >= {1'b0, r_len}) begin
                        if (r_kind == 16'd1 && r_len == 16'd4 && !r_addr_v) begin
                            n_addr_k = n_addr_t;
                            n_addr_v = 1'b1;
                        end else if (r_kind == 16'd33 && r_len >= 16'd6 && r_port_k == 0) begin
                            n_port_k = n_port_t;
                        end else if (r_kind == 16'd16 && r_len_k == 0) begin
                            n_len_k = n_len_t;
                        end
                        n_rec   = r_rec - 18'd1;
                        n_label = '0;
                        n_phase = (r_q_left != 0 || n_rec != 0) ? PH_NAME : PH_DONE;
                    end else begin
                        n_off = r_off + 16'd1;
                    end
                end
                default: ;
            endcase
            if (i_pkt_last) begin
                o_push        = 1'b1;
                o_sum.addr    = n_addr_v ? n_addr_k : 32'd0;
                o_sum.ip_found = n_addr_v;
                o_sum.port    = n_port_k;
                o_sum.len     = n_len_k;
                o_sum.bank    = r_wbank;
                n_wbank       = !r_wbank;
                // clear packet state for the next item stream
                n_phase = PH_HEADER; n_match = TM_0; n_hdr_idx = '0; n_fix_idx = '0;
                n_q_left = '0; n_kind = '0; n_len = '0; n_off = '0; n_rec = '0;
                n_label = '0; n_str_left = '0; n_addr_t = '0; n_addr_k = '0;
                n_addr_v = 1'b0; n_stop = 1'b0; n_port_t = '0; n_port_k = '0;
                n_len_k = '0; n_len_t = '0; n_emit = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_match <= TM_0; r_hdr_idx <= '0; r_fix_idx <= '0;
            r_q_left <= '0; r_kind <= '0; r_len <= '0; r_off <= '0; r_rec <= '0;
            r_label <= '0; r_str_left <= '0; r_addr_t <= '0; r_addr_k <= '0;
            r_addr_v <= 1'b0; r_stop <= 1'b0; r_wbank <= 1'b0; r_port_t <= '0;
            r_port_k <= '0; r_len_k <= '0; r_len_t <= '0; r_emit <= '0;
        end else begin
            r_phase <= n_phase; r_match <= n_match; r_hdr_idx <= n_hdr_idx;
            r_fix_idx <= n_fix_idx; r_q_left <= n_q_left; r_kind <= n_kind; r_len <= n_len;
            r_off <= n_off; r_rec <= n_rec; r_label <= n_label; r_str_left <= n_str_left;
            r_addr_t <= n_addr_t; r_addr_k <= n_addr_k; r_addr_v <= n_addr_v;
            r_stop <= n_stop; r_wbank <= n_wbank; r_port_t <= n_port_t;
            r_port_k <= n_port_k; r_len_k <= n_len_k; r_len_t <= n_len_t; r_emit <= n_emit;
        end
    end

endmodule

// ----- design/dnsrx_back.sv -----
// Result queue, two-bank name memory and result run emitter.
module dnsrx_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  dnsrx_pkg::t_summary           i_sum,
    input  dnsrx_pkg::t_name_wr           i_wr,
    output logic [1:0]                    o_busy,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [31:0]                   o_ipv4_addr,
    output logic                          o_ip_found,
    output logic [15:0]                   o_srv_port,
    output logic [dnsrx_pkg::IDX_W-1:0]   o_name_length,
    output logic [7:0]                    o_name_char,
    output logic                          o_run_end
);
    import dnsrx_pkg::*;

    typedef struct packed {
        t_summary sum;
        logic     last;
    } t_stage;

    logic [7:0]       r_mem [0:2**(IDX_W+1)-1];
    t_summary         r_q [0:1];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt, r_busy;
    logic [IDX_W-1:0] r_k;
    t_stage           r_a;
    logic             r_a_valid, r_o_valid;
    logic [7:0]       r_rdata;

    t_summary         head;
    logic             out_free, a_load_ok, issue, last_k;
    logic [IDX_W:0]   run_len;

    assign head      = r_q[r_rp];
    assign out_free  = !r_o_valid || i_ready;
    assign a_load_ok = !r_a_valid || out_free;
    assign issue     = (r_cnt != 2'd0) && a_load_ok;
    assign run_len   = (head.len == '0) ? (IDX_W+1)'(1) : {1'b0, head.len};
    assign last_k    = ({1'b0, r_k} + 1'b1) == run_len;
    assign o_busy    = r_busy;
    assign o_valid   = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_mem[i_wr.addr] <= i_wr.data;
        if (issue) r_rdata <= r_mem[{head.bank, r_k}];
        if (i_push) r_q[r_wp] <= i_sum;
        if (issue) begin
            r_a.sum  <= head;
            r_a.last <= last_k;
        end
        if (out_free && r_a_valid) begin
            o_ipv4_addr   <= r_a.sum.addr;
            o_ip_found    <= r_a.sum.ip_found;
            o_srv_port    <= r_a.sum.port;
            o_name_length <= r_a.sum.len;
            o_name_char   <= (r_a.sum.len == '0) ? 8'd0 : r_rdata;
            o_run_end     <= r_a.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0; r_busy <= '0; r_k <= '0;
            r_a_valid <= 1'b0; r_o_valid <= 1'b0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, issue && last_k};
            if (i_push) r_busy[i_sum.bank] <= 1'b1;
            if (issue) begin
                if (last_k) begin
                    // bank free once its last character is read out
                    r_busy[head.bank] <= 1'b0;
                    r_rp <= !r_rp;
                    r_k  <= '0;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            if (a_load_ok) r_a_valid <= issue;
            if (out_free) r_o_valid <= r_a_valid;
        end
    end

endmodule

// ----- design/dnsrx_checker.sv -----
// Port-level checks for the DNS response record extractor.
module dnsrx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_ipv4_addr,
    input logic        o_ip_found,
    input logic [5:0]  o_name_length,
    input logic [7:0]  o_name_char,
    input logic        o_run_end
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_name_char) && $stable(o_run_end))
        else $error("stalled result changed");

    a_empty_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_name_length == 6'd0 |-> o_run_end && o_name_char == 8'd0)
        else $error("empty name run malformed");

    a_no_ip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ip_found |-> o_ipv4_addr == 32'd0)
        else $error("address without found flag");
endmodule

bind dns_response_record_extractor_unit dnsrx_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_ipv4_addr(o_ipv4_addr), .o_ip_found(o_ip_found),
    .o_name_length(o_name_length), .o_name_char(o_name_char), .o_run_end(o_run_end)
);
